// ----- hdl/pwc_pkg.sv -----
// shared types, codes and helpers for the primitive widening converter
`timescale 1ns / 1ps
package pwc_pkg;

   typedef enum logic [2:0] {
      TYPE_BOOL   = 3'd0,
      TYPE_BYTE   = 3'd1,
      TYPE_CHAR   = 3'd2,
      TYPE_SHORT  = 3'd3,
      TYPE_INT    = 3'd4,
      TYPE_LONG   = 3'd5,
      TYPE_FLOAT  = 3'd6,
      TYPE_DOUBLE = 3'd7
   } prim_type;

   // conversion kind chosen in the decode stage
   typedef enum logic [2:0] {
      KIND_FAIL   = 3'd0,
      KIND_COPY   = 3'd1,
      KIND_INT    = 3'd2,
      KIND_I2F    = 3'd3,
      KIND_I2D    = 3'd4,
      KIND_F2D    = 3'd5
   } kind_type;

   typedef struct packed {
      logic [2:0]  src_type;
      logic [2:0]  dst_type;
      logic [63:0] value_in;
   } req_type;

   typedef struct packed {
      logic [63:0] value_out;
      logic        ok;
   } rsp_type;

   // decoded item between stage one and stage two
   typedef struct packed {
      kind_type    kind;
      logic [2:0]  dst_type;
      logic [63:0] value;     // raw bits for copy/f2d, sign- or zero-extended value otherwise
      logic        sign;
      logic [63:0] mag;       // magnitude for int to float/double
   } dec_type;

   // normalized item between stage two and stage three
   typedef struct packed {
      kind_type    kind;
      logic [2:0]  dst_type;
      logic [63:0] value;
      logic        sign;
      logic [63:0] norm;      // magnitude shifted so bit 63 is the leading one
      logic [5:0]  msb;
      logic        zero;
   } nrm_type;

   // position of the leading one, zero when x is zero
   function automatic logic [5:0] msb_pos(input logic [63:0] x);
      logic [5:0] p;
      p = '0;
      for (int i = 0; i < 64; i++) begin
         if (x[i]) p = 6'(i);
      end
      return p;
   endfunction

   function automatic logic allowed(input logic [2:0] s, input logic [2:0] d);
      logic a;
      case (s)
         TYPE_BYTE:  a = (d >= TYPE_SHORT);
         TYPE_CHAR,
         TYPE_SHORT: a = (d >= TYPE_INT);
         TYPE_INT:   a = (d >= TYPE_LONG);
         TYPE_LONG:  a = (d >= TYPE_FLOAT);
         TYPE_FLOAT: a = (d == TYPE_DOUBLE);
         default:    a = 1'b0;
      endcase
      return a;
   endfunction

endpackage

// ----- hdl/pwc_decode.sv -----
// stage one: pair check, sign extension and magnitude
`timescale 1ns / 1ps
module pwc_decode (
   input  pwc_pkg::req_type req,
   output pwc_pkg::dec_type dec
);
   logic [63:0] iv;

   always_comb begin
      case (req.src_type)
         pwc_pkg::TYPE_BYTE:  iv = {{56{req.value_in[7]}}, req.value_in[7:0]};
         pwc_pkg::TYPE_CHAR:  iv = {48'd0, req.value_in[15:0]};
         pwc_pkg::TYPE_SHORT: iv = {{48{req.value_in[15]}}, req.value_in[15:0]};
         pwc_pkg::TYPE_INT:   iv = {{32{req.value_in[31]}}, req.value_in[31:0]};
         default:             iv = req.value_in;
      endcase
      dec.dst_type = req.dst_type;
      dec.sign     = iv[63];
      dec.mag      = iv[63] ? (64'd0 - iv) : iv;
      dec.value    = iv;
      if (req.src_type == req.dst_type) begin
         dec.kind  = pwc_pkg::KIND_COPY;
         dec.value = req.value_in;
      end else if (!pwc_pkg::allowed(req.src_type, req.dst_type)) begin
         dec.kind = pwc_pkg::KIND_FAIL;
      end else if (req.src_type == pwc_pkg::TYPE_FLOAT) begin
         dec.kind  = pwc_pkg::KIND_F2D;
         dec.value = {32'd0, req.value_in[31:0]};
      end else if (req.dst_type == pwc_pkg::TYPE_FLOAT) begin
         dec.kind = pwc_pkg::KIND_I2F;
      end else if (req.dst_type == pwc_pkg::TYPE_DOUBLE) begin
         dec.kind = pwc_pkg::KIND_I2D;
      end else begin
         dec.kind = pwc_pkg::KIND_INT;
      end
   end
endmodule

// ----- hdl/pwc_normalize.sv -----
// stage two: leading-one search and normalizing shift
`timescale 1ns / 1ps
module pwc_normalize (
   input  pwc_pkg::dec_type dec,
   output pwc_pkg::nrm_type nrm
);
   logic [63:0] src;
   logic [5:0]  p;

   always_comb begin
      // float to double reuses the search on the 23-bit mantissa
      src = (dec.kind == pwc_pkg::KIND_F2D) ? {41'd0, dec.value[22:0]} : dec.mag;
      p   = pwc_pkg::msb_pos(src);
      nrm.kind     = dec.kind;
      nrm.dst_type = dec.dst_type;
      nrm.value    = dec.value;
      nrm.sign     = dec.sign;
      nrm.msb      = p;
      nrm.zero     = (src == 64'd0);
      nrm.norm     = src << (6'd63 - p);
   end
endmodule

// ----- hdl/pwc_pack.sv -----
// stage three: rounding and result packing
`timescale 1ns / 1ps
module pwc_pack (
   input  pwc_pkg::nrm_type nrm,
   output pwc_pkg::rsp_type rsp
);
   logic [24:0] fm;
   logic [53:0] dm;
   logic        f_rup, d_rup;
   logic [7:0]  fe;
   logic [10:0] de;
   logic [7:0]  se;
   logic [22:0] sm;
   logic [51:0] nm;

   always_comb begin
      // single: keep 24 bits, guard at bit 39, sticky below
      f_rup = nrm.norm[39] && ((|nrm.norm[38:0]) || nrm.norm[40]);
      fm    = {1'b0, nrm.norm[63:40]} + 25'(f_rup);
      fe    = 8'(nrm.msb) + 8'd127 + 8'(fm[24]);
      d_rup = nrm.norm[10] && ((|nrm.norm[9:0]) || nrm.norm[11]);
      dm    = {1'b0, nrm.norm[63:11]} + 54'(d_rup);
      de    = 11'(nrm.msb) + 11'd1023 + 11'(dm[53]);
      se    = nrm.value[30:23];
      sm    = nrm.value[22:0];
      nm    = {nrm.norm[62:11]};
      rsp.ok        = 1'b1;
      rsp.value_out = '0;
      case (nrm.kind)
         pwc_pkg::KIND_COPY: rsp.value_out = nrm.value;
         pwc_pkg::KIND_INT: begin
            if (nrm.dst_type == pwc_pkg::TYPE_SHORT)
               rsp.value_out = {48'd0, nrm.value[15:0]};
            else if (nrm.dst_type == pwc_pkg::TYPE_INT)
               rsp.value_out = {32'd0, nrm.value[31:0]};
            else
               rsp.value_out = nrm.value;
         end
         pwc_pkg::KIND_I2F: begin
            if (!nrm.zero)
               rsp.value_out = {32'd0, nrm.sign, fe, fm[24] ? fm[23:1] : fm[22:0]};
         end
         pwc_pkg::KIND_I2D: begin
            if (!nrm.zero)
               rsp.value_out = {nrm.sign, de, dm[53] ? dm[52:1] : dm[51:0]};
         end
         pwc_pkg::KIND_F2D: begin
            if (se == 8'hFF)
               rsp.value_out = {nrm.value[31], 11'h7FF,
                                (sm == 23'd0) ? 52'd0 : {1'b1, sm[21:0], 29'd0}};
            else if (se == 8'd0)
               rsp.value_out = (sm == 23'd0) ? {nrm.value[31], 63'd0} :
                  {nrm.value[31], 11'(nrm.msb) + 11'd874, nm};
            else
               rsp.value_out = {nrm.value[31], 11'(se) + 11'd896, sm, 29'd0};
         end
         default: rsp.ok = 1'b0;
      endcase
   end
endmodule

// ----- hdl/primitive_widening_converter.sv -----
// top level of the primitive widening converter
`timescale 1ns / 1ps
// Converts one primitive value per cycle when not stalled, following the
// language's widening rules: integer sign or zero extension, integer to
// float/double with round-to-nearest-even, and exact float to double with
// quieted NaNs. Equal types copy all 64 bits; a disallowed pair gives zero
// with ok low. Each item passes the decode, normalize, and round and pack
// register stages in order; one item can enter every cycle unless a stall
// from the result side freezes the whole pipeline. req_stall is rsp_stall
// while the output stage holds an item, so nothing is lost or repeated.
module primitive_widening_converter (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  pwc_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output pwc_pkg::rsp_type rsp_data
);
   pwc_pkg::dec_type dec_in, dec_ff;
   pwc_pkg::nrm_type nrm_in, nrm_ff;
   pwc_pkg::rsp_type rsp_in, rsp_ff;
   logic             v1_ff, v2_ff, v3_ff;
   logic             advance;

   // pipeline moves unless a held result is being refused
   assign advance   = !(v3_ff && rsp_stall);
   assign req_stall = !advance;
   assign rsp_valid = v3_ff;
   assign rsp_data  = rsp_ff;

   pwc_decode    u_decode    (.req(req_data), .dec(dec_in));
   pwc_normalize u_normalize (.dec(dec_ff),   .nrm(nrm_in));
   pwc_pack      u_pack      (.nrm(nrm_ff),   .rsp(rsp_in));

   // valid bits travel with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= req_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   // payload stages, no reset needed
   always_ff @(posedge clock) begin
      if (advance) begin
         dec_ff <= dec_in;
         nrm_ff <= nrm_in;
         rsp_ff <= rsp_in;
      end
   end
endmodule

// ----- hdl/pwc_checker.sv -----
// port-level checks for the primitive widening converter
`timescale 1ns / 1ps
module pwc_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input pwc_pkg::rsp_type rsp_data
);
   // a held result stays put
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // input is only held back by a refused result
   a_stall: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without cause");

   // an item accepted while the result side does not stall reaches the output
   a_lat: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall ##1 !rsp_stall ##1 !rsp_stall |=> rsp_valid)
      else $error("item lost in pipeline");

   // a failed conversion carries zero bits
   a_fail: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.ok |-> rsp_data.value_out == 64'd0)
      else $error("failed item with nonzero value");
endmodule

bind primitive_widening_converter pwc_checker u_pwc_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
);
